// ----- hdl/pcv_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pcv_pkg
// Shared types and constants for the packet CRC-16 validator: request and
// response payloads, verdict codes and CRC-16/CCITT-FALSE constants.
// ----------------------------------------------------------------------------
package pcv_pkg;

   // Default packet size in bytes, CRC trailer included
   localparam int PacketBytesDefault = 32;

   // Width of the byte counter; it saturates at its all-ones value
   localparam int CountWidth = 8;

   // CRC-16/CCITT-FALSE
   localparam logic [15:0] CrcInit = 16'hFFFF;
   localparam logic [15:0] CrcTop  = 16'h8000;
   localparam logic [15:0] CrcPoly = 16'h1021;

   // Reset value of the expected protocol version
   localparam logic [7:0] VersionReset = 8'd3;

   // Verdict codes, first failing check wins
   localparam logic [1:0] StatusOk      = 2'd0;
   localparam logic [1:0] StatusLength  = 2'd1;
   localparam logic [1:0] StatusVersion = 2'd2;
   localparam logic [1:0] StatusCrc     = 2'd3;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic        packet_ok;
      logic [1:0]  status;
      logic [15:0] computed_crc;
   } rsp_type;

endpackage : pcv_pkg
`default_nettype wire

// ----- hdl/pcv_crc_byte.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pcv_crc_byte
// One-byte CRC-16/CCITT-FALSE update, MSB first, unrolled over eight bits.
// ----------------------------------------------------------------------------
module pcv_crc_byte (
   input  wire logic [15:0] crc_in,
   input  wire logic [7:0]  data,
   output logic      [15:0] crc_out
);

   // Fold the byte into the top, then shift out eight bits
   always_comb begin
      logic [15:0] c;
      c = crc_in ^ {data, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if ((c & pcv_pkg::CrcTop) != 16'h0000) begin
            c = {c[14:0], 1'b0} ^ pcv_pkg::CrcPoly;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      crc_out = c;
   end

endmodule : pcv_crc_byte
`default_nettype wire

// ----- hdl/pcv_tracker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pcv_tracker
// Per-packet state: byte count, running CRC, received CRC trailer and the
// version flag. Produces the verdict on the request flagged as last byte.
// ----------------------------------------------------------------------------
module pcv_tracker #(
   parameter int PACKET_BYTES = pcv_pkg::PacketBytesDefault
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             fire,
   input  wire pcv_pkg::req_type req,
   input  wire logic [7:0]       version,
   output logic                  result_valid,
   output pcv_pkg::rsp_type      result
);

   localparam int CW = pcv_pkg::CountWidth;
   localparam logic [CW-1:0] BodyEnd  = CW'(PACKET_BYTES - 2);
   localparam logic [CW-1:0] CrcLoPos = CW'(PACKET_BYTES - 2);
   localparam logic [CW-1:0] CrcHiPos = CW'(PACKET_BYTES - 1);
   localparam logic [CW-1:0] LastPos  = CW'(PACKET_BYTES - 1);
   localparam logic [CW-1:0] CountMax = {CW{1'b1}};
   localparam logic [CW-1:0] CountOne = CW'(1);

   logic [CW-1:0] count_ff, count_in;
   logic [15:0]   crc_ff, crc_in;
   logic [15:0]   rx_crc_ff, rx_crc_in;
   logic          ver_bad_ff, ver_bad_in;

   logic [15:0]   crc_step;
   logic [15:0]   crc_upd;
   logic [15:0]   rx_upd;
   logic          ver_bad_upd;

   pcv_crc_byte u_crc_byte (
      .crc_in  (crc_ff),
      .data    (req.data_byte),
      .crc_out (crc_step)
   );

   // State after this byte, before any end-of-packet clear
   always_comb begin
      ver_bad_upd = ver_bad_ff
                    | ((count_ff == '0) && (req.data_byte != version));
      crc_upd = crc_ff;
      rx_upd  = rx_crc_ff;
      if (count_ff < BodyEnd) begin
         crc_upd = crc_step;
      end else if (count_ff == CrcLoPos) begin
         rx_upd = {rx_crc_ff[15:8], req.data_byte};
      end else if (count_ff == CrcHiPos) begin
         rx_upd = {req.data_byte, rx_crc_ff[7:0]};
      end
   end

   // Verdict, checks in priority order
   always_comb begin
      result_valid = fire && req.last_byte;
      if ((count_ff == CountMax) || (count_ff != LastPos)) begin
         result.status = pcv_pkg::StatusLength;
      end else if (ver_bad_upd) begin
         result.status = pcv_pkg::StatusVersion;
      end else if (rx_upd != crc_upd) begin
         result.status = pcv_pkg::StatusCrc;
      end else begin
         result.status = pcv_pkg::StatusOk;
      end
      result.packet_ok    = (result.status == pcv_pkg::StatusOk);
      result.computed_crc = crc_upd;
   end

   // Next state: advance on every request, clear after the last byte
   always_comb begin
      count_in   = count_ff;
      crc_in     = crc_ff;
      rx_crc_in  = rx_crc_ff;
      ver_bad_in = ver_bad_ff;
      if (fire) begin
         if (req.last_byte) begin
            count_in   = '0;
            crc_in     = pcv_pkg::CrcInit;
            rx_crc_in  = 16'h0000;
            ver_bad_in = 1'b0;
         end else begin
            count_in   = (count_ff == CountMax) ? count_ff : count_ff + CountOne;
            crc_in     = crc_upd;
            rx_crc_in  = rx_upd;
            ver_bad_in = ver_bad_upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         crc_ff     <= pcv_pkg::CrcInit;
         rx_crc_ff  <= 16'h0000;
         ver_bad_ff <= 1'b0;
      end else begin
         count_ff   <= count_in;
         crc_ff     <= crc_in;
         rx_crc_ff  <= rx_crc_in;
         ver_bad_ff <= ver_bad_in;
      end
   end

endmodule : pcv_tracker
`default_nettype wire

// ----- hdl/packet_crc16_validator.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// packet_crc16_validator
// Checks packets that arrive one byte per request and gives one verdict
// (length, version, CRC-16/CCITT-FALSE) per packet.
// ----------------------------------------------------------------------------
// The block takes one byte per clock cycle, back to back, for as long as the
// response side keeps up. The verdict for a packet appears on rsp_valid in
// the cycle after its last byte is accepted and is held in a result register;
// while that register is full and not being drained, or while reset is high,
// req_ready drops and requests wait. The cycle time is set by the eight-bit
// unrolled CRC update followed by the 16-bit trailer compare. The expected
// version is written through csr_wr_en/csr_wr_data and resets to 3.
module packet_crc16_validator #(
   parameter int PACKET_BYTES = pcv_pkg::PacketBytesDefault
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire pcv_pkg::req_type req_payload,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output pcv_pkg::rsp_type      rsp_payload,
   input  wire logic             csr_wr_en,
   input  wire logic [7:0]       csr_wr_data
);

   logic [7:0]       ver_ff, ver_in;
   logic             rsp_valid_ff, rsp_valid_in;
   pcv_pkg::rsp_type rsp_ff, rsp_in;
   logic             out_free;
   logic             req_fire;
   logic             result_valid;
   pcv_pkg::rsp_type result;

   // Result register free, or being drained this cycle
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = out_free && !reset;
   assign req_fire  = req_valid && req_ready;

   pcv_tracker #(
      .PACKET_BYTES (PACKET_BYTES)
   ) u_tracker (
      .clock        (clock),
      .reset        (reset),
      .fire         (req_fire),
      .req          (req_payload),
      .version      (ver_ff),
      .result_valid (result_valid),
      .result       (result)
   );

   // Version register
   assign ver_in = csr_wr_en ? csr_wr_data : ver_ff;

   // Result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (out_free) begin
         rsp_valid_in = result_valid;
      end
      if (result_valid) begin
         rsp_in = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ver_ff       <= pcv_pkg::VersionReset;
         rsp_valid_ff <= 1'b0;
      end else begin
         ver_ff       <= ver_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule : packet_crc16_validator
`default_nettype wire

// ----- hdl/pcv_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pcv_checker
// Port-level checks for the packet CRC-16 validator, bound to the top level.
// ----------------------------------------------------------------------------
module pcv_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_ready,
   input wire pcv_pkg::req_type req_payload,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire pcv_pkg::rsp_type rsp_payload
);

   // Stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("response changed while stalled");

   // packet_ok agrees with status
   a_ok_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.packet_ok == (rsp_payload.status == pcv_pkg::StatusOk)))
      else $error("packet_ok disagrees with status");

   // A new response follows an accepted last byte
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !$past(rsp_valid) |->
         $past(req_valid && req_ready && req_payload.last_byte))
      else $error("response without a last byte");

   // A non-final byte never produces a response
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !req_payload.last_byte && !(rsp_valid && !rsp_ready)
         |=> !rsp_valid)
      else $error("response after a non-final byte");

   // Requests flow whenever the result register is empty
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with empty output");

endmodule : pcv_checker

bind packet_crc16_validator pcv_checker u_pcv_checker (.*);
`default_nettype wire
